FILE: rtl/assert_macros.svh
// assertion macros shared by the sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define CKS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property whose consequent must hold in the cycle after the antecedent
`define CKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CKS_ASSERT(label, prop, msg)
`define CKS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/cks_pkg.sv
// types, constants and key compare for the composite key record sorter
`default_nettype none

package cks_pkg;

    localparam int RECORDS    = 256;
    localparam int TEXT_BYTES = 8;
    localparam int TEXT_W     = TEXT_BYTES * 8;
    localparam int YEAR_W     = 12;
    localparam int IDX_W      = $clog2(RECORDS);
    localparam int CNT_W      = $clog2(RECORDS + 1);

    // stream word widths, padded to whole bytes
    localparam int S_DATA_W   = 144;
    localparam int M_DATA_W   = 152;

    // item kinds on the input tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // result status on the output tuser
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [TEXT_W-1:0] branch;
        logic [YEAR_W-1:0] year;
        logic [TEXT_W-1:0] roll;
        logic [IDX_W-1:0]  idx;
    } cks_rec_t;

    // chain commands, broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } cks_ctrl_t;

    // a sorts strictly after b on branch, year, roll
    function automatic logic rec_after(input cks_rec_t a, input cks_rec_t b);
        return {a.branch, a.year, a.roll} > {b.branch, b.year, b.roll};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cks_cell.sv
// one slot of the insertion chain: holds a record and shifts with its neighbors
`default_nettype none

`include "assert_macros.svh"

module cks_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cks_pkg::cks_ctrl_t ctrl,
    input  wire cks_pkg::cks_rec_t  new_rec,
    input  wire cks_pkg::cks_rec_t  left_rec,
    input  wire logic              left_valid,
    input  wire logic              left_after,
    input  wire cks_pkg::cks_rec_t  right_rec,
    input  wire logic              right_valid,
    output cks_pkg::cks_rec_t       rec,
    output logic                   valid,
    output logic                   after
);
    import cks_pkg::*;

    cks_rec_t rec_reg;
    cks_rec_t rec_next;
    logic     valid_reg;
    logic     valid_next;

    // new record belongs in front of this slot
    assign after = !valid_reg || rec_after(rec_reg, new_rec);

    // insert shifts right from the insertion point, extract shifts left
    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            if (after)
            begin
                if (left_after)
                begin
                    rec_next   = left_rec;
                    valid_next = left_valid;
                end
                else
                begin
                    rec_next   = new_rec;
                    valid_next = 1'b1;
                end
            end
        end
        else if (ctrl.ext)
        begin
            rec_next   = right_rec;
            valid_next = right_valid;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

    // order against the right neighbor
    `CKS_ASSERT(a_cell_order, !(valid_reg && right_valid && rec_after(rec_reg, right_rec)), "cell out of order with right neighbor")

endmodule

`default_nettype wire

FILE: rtl/composite_key_record_sorter.sv
// composite key record sorter: insertion chain of cells with stream in and out
//
//  channel   dir  tdata                                   tuser    tlast
//  s_axis    in   branch_code, year, roll_code            func     -
//  m_axis    out  sorted_branch, sorted_year, sorted_roll, status   last_of_run
//                 arrival_index, overflowed
//
// one word per cycle on the input while not stalled: a load inserts into the cell chain
// and a read removes the head of the chain
// a read result sits in one output register; input is stalled only while that
// register is full and not taken
// reset clears the cell occupancy bits, the load position and the overflow flag;
// the chain is usable in the first cycle after reset
`default_nettype none

`include "assert_macros.svh"

module composite_key_record_sorter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // branch_code[63:0], year[75:64], roll_code[139:76], zero pad
    input  wire logic [cks_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // sorted_branch[63:0], sorted_year[75:64], sorted_roll[139:76],
    // arrival_index[147:140], overflowed[148], zero pad
    output logic [cks_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // status
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import cks_pkg::*;

    cks_ctrl_t        ctrl;
    cks_rec_t         new_rec;
    cks_rec_t         rec_vec   [RECORDS];
    logic [RECORDS-1:0] valid_vec;
    logic [RECORDS-1:0] after_vec;

    logic             accept;
    logic             is_load;
    logic             is_read;
    logic             load_ok;

    logic [CNT_W-1:0] load_cnt_reg;
    logic [CNT_W-1:0] load_cnt_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic                out_status_reg;
    logic                out_status_next;
    logic                out_last_reg;
    logic                out_last_next;

    // input decode
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = accept && (s_axis_tuser == FUNC_LOAD);
    assign is_read       = accept && (s_axis_tuser == FUNC_READ);
    assign load_ok       = is_load && (load_cnt_reg < CNT_W'(RECORDS));
    assign ctrl.ins      = load_ok;
    assign ctrl.ext      = is_read && valid_vec[0];

    // record being inserted, sliced from the input word
    assign new_rec.branch = s_axis_tdata[TEXT_W-1:0];
    assign new_rec.year   = s_axis_tdata[75:64];
    assign new_rec.roll   = s_axis_tdata[76 +: TEXT_W];
    assign new_rec.idx    = load_cnt_reg[IDX_W-1:0];

    // the cell chain
    for (genvar i = 0; i < RECORDS; i++)
    begin : g_cell
        cks_rec_t lrec;
        logic     lvalid;
        logic     lafter;
        cks_rec_t rrec;
        logic     rvalid;

        if (i == 0)
        begin : g_head
            assign lrec   = new_rec;
            assign lvalid = 1'b0;
            assign lafter = 1'b0;
        end
        else
        begin : g_body
            assign lrec   = rec_vec[i-1];
            assign lvalid = valid_vec[i-1];
            assign lafter = after_vec[i-1];
        end

        if (i == RECORDS - 1)
        begin : g_tail
            assign rrec   = new_rec;
            assign rvalid = 1'b0;
        end
        else
        begin : g_mid
            assign rrec   = rec_vec[i+1];
            assign rvalid = valid_vec[i+1];
        end

        cks_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_rec     (new_rec),
            .left_rec    (lrec),
            .left_valid  (lvalid),
            .left_after  (lafter),
            .right_rec   (rrec),
            .right_valid (rvalid),
            .rec         (rec_vec[i]),
            .valid       (valid_vec[i]),
            .after       (after_vec[i])
        );
    end

    // load position and sticky overflow, both cleared when a read removes the last record
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        ovf_next      = ovf_reg;
        priority if (load_ok)
            load_cnt_next = load_cnt_reg + CNT_W'(1);
        else if (is_load)
            ovf_next = 1'b1;
        else if (ctrl.ext && !valid_vec[1])
        begin
            load_cnt_next = '0;
            ovf_next      = 1'b0;
        end
        else
        begin
            load_cnt_next = load_cnt_reg;
            ovf_next      = ovf_reg;
        end
    end

    // result word built from the chain head
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (is_read)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            if (valid_vec[0])
            begin
                out_data_next[63:0]    = 64'(rec_vec[0].branch);
                out_data_next[75:64]   = rec_vec[0].year;
                out_data_next[139:76]  = 64'(rec_vec[0].roll);
                out_data_next[147:140] = 8'(rec_vec[0].idx);
            end
            out_data_next[148] = ovf_reg;
            out_status_next    = valid_vec[0] ? STATUS_OK : STATUS_EMPTY;
            out_last_next      = valid_vec[0] && !valid_vec[1];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_cnt_reg  <= load_cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // occupied cells stay packed at the head of the chain
    `CKS_ASSERT(a_packed, (valid_vec[RECORDS-1:1] & ~valid_vec[RECORDS-2:0]) == '0, "gap in cell chain")
    // never more records held than loads taken since empty
    `CKS_ASSERT(a_count, $countones(valid_vec) <= int'(load_cnt_reg), "more records than loads")
    // removing the last record restarts the load position
    `CKS_ASSERT_NEXT(a_restart, ctrl.ext && !valid_vec[1], load_cnt_reg == '0 && !valid_vec[0] && !ovf_reg, "store not restarted after last read")
    // a waiting result is not lost
    `CKS_ASSERT_NEXT(a_hold, out_valid_reg && !m_axis_tready, out_valid_reg && $stable(out_data_reg), "pending result dropped")

endmodule

`default_nettype wire
